// ----- sv/wcg_pkg.sv -----
// ----------------------------------------------------------------------------
// wcg_pkg
// types, constants and helpers shared by the window coefficient generator
// ----------------------------------------------------------------------------
`default_nettype none

package wcg_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int IDX_W      = 12;
  localparam int LEN_W      = 13;
  localparam int LM1_W      = 12;
  localparam int COEF_W     = 16;
  localparam int FRAC_BITS  = 15;
  localparam int PH_W       = 20;
  localparam int DVD_W      = 32;
  localparam int QUO_W      = 21;
  localparam int COS_STAGES = 15;
  localparam int FIFO_DEPTH = 2;
  // through the queue, then the divider and cosine pipelines
  localparam int RESULT_LATENCY = 1 + QUO_W + COS_STAGES;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  // floor(2^32 / k) for the series divisors 132, 90, 56, 30, 12
  localparam logic [31:0] RECIP [5] = '{32'd32537631, 32'd47721858, 32'd76695844,
                                        32'd143165576, 32'd357913941};
  localparam logic [7:0]  DIVS  [5] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12};
  // ceil(2^29 / 100), exact for the 22-bit rounding operand
  localparam logic [22:0] RECIP_100 = 23'd5368710;

  localparam logic [0:0] REG_WINDOW_TYPE   = 1'b0;
  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    WIN_HANN     = 2'd0,
    WIN_HAMMING  = 2'd1,
    WIN_BARTLETT = 2'd2,
    WIN_RECT     = 2'd3
  } win_e;

  typedef enum logic [1:0] {
    KIND_COS = 2'd0,
    KIND_TRI = 2'd1,
    KIND_ONE = 2'd2,
    KIND_OOR = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  hamming;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [DVD_W-1:0]  dividend;
  } job_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] lim;
    lim = LEN_W'(MAX_LENGTH);
    return (len > lim) ? lim : len;
  endfunction

  function automatic logic [LM1_W-1:0] len_m1(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] d;
    d = n - LEN_W'(1);
    return d[LM1_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/wcg_front.sv -----
// ----------------------------------------------------------------------------
// wcg_front
// classifies an index and builds the divider operand
// ----------------------------------------------------------------------------
`default_nettype none

module wcg_front import wcg_pkg::*; (
  input  logic [IDX_W-1:0] sample_index_i,
  input  win_e             win_i,
  input  logic [LEN_W-1:0] len_i,
  output job_t             job_o
);

  logic [LEN_W-1:0] n;
  logic [LM1_W-1:0] lm1;
  logic [LEN_W-1:0] twice;
  logic [LEN_W-1:0] lm1_x;
  logic [LEN_W-1:0] d;
  logic [LM1_W-1:0] tri_num;
  logic             oor;

  always_comb begin
    n       = sat_len(len_i);
    lm1     = len_m1(n);
    lm1_x   = {1'b0, lm1};
    twice   = {sample_index_i, 1'b0};
    d       = (twice > lm1_x) ? twice - lm1_x : lm1_x - twice;
    tri_num = lm1 - d[LM1_W-1:0];
    oor     = ({1'b0, sample_index_i} >= n);

    job_o.side.hamming = (win_i == WIN_HAMMING);
    job_o.dividend     = {sample_index_i, {PH_W{1'b0}}} + DVD_W'(lm1 >> 1);
    if (oor) begin
      job_o.side.kind = KIND_OOR;
    end else if (n == LEN_W'(1)) begin
      job_o.side.kind = KIND_ONE;
    end else begin
      unique case (win_i)
        WIN_HANN, WIN_HAMMING: job_o.side.kind = KIND_COS;
        WIN_BARTLETT: begin
          job_o.side.kind = KIND_TRI;
          job_o.dividend  = DVD_W'({tri_num, {FRAC_BITS{1'b0}}}) + DVD_W'(lm1 >> 1);
        end
        default: job_o.side.kind = KIND_ONE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/wcg_fifo.sv -----
// ----------------------------------------------------------------------------
// wcg_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module wcg_fifo import wcg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o,
  output logic full_o
);

  job_t       mem_q [FIFO_DEPTH];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'(FIFO_DEPTH));
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/wcg_div.sv -----
// ----------------------------------------------------------------------------
// wcg_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module wcg_div import wcg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  job_t             job_i,
  input  logic [LM1_W-1:0] divisor_i,
  output logic             out_valid_o,
  output logic [QUO_W-1:0] quo_o,
  output side_t            side_o
);

  logic             v_q   [QUO_W];
  logic [LM1_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DVD_W-1:0] dvd_q [QUO_W];
  side_t            sd_q  [QUO_W];

  logic             v_in   [QUO_W];
  logic [LM1_W-1:0] rem_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic [DVD_W-1:0] dvd_in [QUO_W];
  side_t            sd_in  [QUO_W];

  always_comb begin
    v_in[0]   = in_valid_i;
    rem_in[0] = LM1_W'(job_i.dividend[DVD_W-1:QUO_W]);
    quo_in[0] = '0;
    dvd_in[0] = job_i.dividend;
    sd_in[0]  = job_i.side;
    for (int k = 1; k < QUO_W; k++) begin
      v_in[k]   = v_q[k-1];
      rem_in[k] = rem_q[k-1];
      quo_in[k] = quo_q[k-1];
      dvd_in[k] = dvd_q[k-1];
      sd_in[k]  = sd_q[k-1];
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [LM1_W:0] trial;
    logic           ge;

    assign trial = {rem_in[k], dvd_in[k][QUO_W-1-k]};
    assign ge    = (trial >= {1'b0, divisor_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? LM1_W'(trial - {1'b0, divisor_i}) : trial[LM1_W-1:0];
      quo_q[k] <= {quo_in[k][QUO_W-2:0], ge};
      dvd_q[k] <= dvd_in[k];
      sd_q[k]  <= sd_in[k];
    end
  end

  assign out_valid_o = v_q[QUO_W-1];
  assign quo_o       = quo_q[QUO_W-1];
  assign side_o      = sd_q[QUO_W-1];

endmodule

`default_nettype wire

// ----- sv/wcg_cos.sv -----
// ----------------------------------------------------------------------------
// wcg_cos
// cosine series pipeline and final coefficient select
// ----------------------------------------------------------------------------
`default_nettype none

module wcg_cos import wcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [QUO_W-1:0]  quo_i,
  input  side_t             side_i,
  output logic              out_valid_o,
  output logic [COEF_W-1:0] coef_o,
  output logic              oor_o
);

  typedef struct packed {
    side_t              side;
    logic               neg;
    logic [COEF_W-1:0]  tri_coef;
  } pipe_t;

  logic  v_q  [COS_STAGES];
  pipe_t pd_q [COS_STAGES];

  logic [18:0] q_q;
  logic [50:0] px_q;
  logic [61:0] sq_q;
  logic [31:0] x2_q, x2b_q;
  logic [63:0] pk_q [5];
  logic [28:0] qk_q [5];
  logic [30:0] t_q  [5];
  logic [31:0] x2c_q [5];
  logic [28:0] qc_q [5][5];
  logic [62:0] pf_q;
  logic [30:0] m_q;
  logic [37:0] num_q;
  logic [45:0] py_q;
  logic [COEF_W-1:0] coef_q;
  logic              oor_q;

  // stage 1: fold the phase into one quarter
  logic [1:0]  quad;
  logic [17:0] rr;
  pipe_t       pd_in;

  always_comb begin
    quad           = quo_i[PH_W-1:PH_W-2];
    rr             = quo_i[PH_W-3:0];
    pd_in.side     = side_i;
    pd_in.neg      = (quad == 2'd1) || (quad == 2'd2);
    pd_in.tri_coef = quo_i[COEF_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < COS_STAGES; k++) v_q[k] <= 1'b0;
    end else begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < COS_STAGES; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pd_q[0] <= pd_in;
    for (int k = 1; k < COS_STAGES; k++) pd_q[k] <= pd_q[k-1];
    q_q <= quad[0] ? 19'h40000 - {1'b0, rr} : {1'b0, rr};
  end

  // stages 2 to 5: angle, square and the five series quotients
  logic [31:0] x;
  logic [31:0] x2;
  logic [32:0] r_k  [5];
  logic [28:0] q0_k [5];

  always_comb begin
    x  = {1'b0, px_q[49:19]};
    x2 = sq_q[61:30];
    for (int k = 0; k < 5; k++) begin
      q0_k[k] = pk_q[k][60:32];
      r_k[k]  = {1'b0, x2_q} - 33'(q0_k[k] * DIVS[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= 51'(q_q * PI_Q30);
    sq_q  <= 62'(x[30:0] * x[30:0]);
    x2_q  <= x2;
    x2b_q <= x2_q;
    for (int k = 0; k < 5; k++) begin
      pk_q[k] <= 64'(x2 * RECIP[k]);
      qk_q[k] <= (r_k[k] >= 33'(DIVS[k])) ? q0_k[k] + 29'd1 : q0_k[k];
    end
  end

  // stages 6 to 10: nested series t = 1 - (x2/k) * t
  logic [30:0] t_in  [5];
  logic [31:0] x2_in [5];
  logic [28:0] q_in  [5][5];
  logic [59:0] prod  [5];

  always_comb begin
    t_in[0]  = Q30_ONE;
    x2_in[0] = x2b_q;
    q_in[0]  = qk_q;
    for (int j = 1; j < 5; j++) begin
      t_in[j]  = t_q[j-1];
      x2_in[j] = x2c_q[j-1];
      q_in[j]  = qc_q[j-1];
    end
    for (int j = 0; j < 5; j++) begin
      prod[j] = 60'(q_in[j][j] * t_in[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 5; j++) begin
      t_q[j]   <= Q30_ONE - 31'(prod[j][59:30]);
      x2c_q[j] <= x2_in[j];
      qc_q[j]  <= q_in[j];
    end
  end

  // stages 11 to 15: magnitude, window blend, rounding, select
  logic [31:0] a;
  logic [37:0] alpha30;
  logic [37:0] bm;
  logic [6:0]  beta;
  logic [22:0] y;
  logic [16:0] c;

  always_comb begin
    a       = pf_q[62:31];
    beta    = pd_q[11].side.hamming ? 7'd46 : 7'd50;
    alpha30 = pd_q[11].side.hamming ? {8'd54, 30'd0} : {8'd50, 30'd0};
    bm      = 38'(beta * m_q);
    y       = 23'(num_q[37:15]) + 23'd50;
    c       = py_q[45:29];
  end

  always_ff @(posedge clk_i) begin
    pf_q  <= 63'(x2c_q[4] * t_q[4]);
    m_q   <= (a >= {1'b0, Q30_ONE}) ? 31'd0 : Q30_ONE - a[30:0];
    num_q <= pd_q[11].neg ? alpha30 + bm : alpha30 - bm;
    py_q  <= 46'(y * RECIP_100);
    oor_q <= (pd_q[13].side.kind == KIND_OOR);
    case (pd_q[13].side.kind)
      KIND_COS: coef_q <= c[COEF_W-1:0];
      KIND_TRI: coef_q <= pd_q[13].tri_coef;
      KIND_ONE: coef_q <= COEF_W'(1 << FRAC_BITS);
      default:  coef_q <= '0;
    endcase
  end

  assign out_valid_o = v_q[COS_STAGES-1];
  assign coef_o      = coef_q;
  assign oor_o       = oor_q;

endmodule

`default_nettype wire

// ----- sv/window_coefficient_generator_unit.sv -----
// ----------------------------------------------------------------------------
// window_coefficient_generator_unit
// hann, hamming, bartlett and rectangular window weights in unsigned q1.15
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------
//  command   | start / busy               | sample_index_i
//  config    | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//  result    | result_valid_o (strobe)    | coefficient_o, index_out_of_range_o
//
//  one index per clock while busy is low; each result passes through the
//  queue, the 21-stage divider (one quotient bit per stage) and the 15-stage
//  cosine series pipeline
//  reset loads hamming, length 1024, and empties every pipeline
//  results cannot be held off; busy only rises if the queue ever fills
// ----------------------------------------------------------------------------
`default_nettype none

module window_coefficient_generator_unit import wcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [IDX_W-1:0]  sample_index_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [LEN_W-1:0]  cfg_data_i,
  output logic              result_valid_o,
  output logic [COEF_W-1:0] coefficient_o,
  output logic              index_out_of_range_o
);

  // configuration registers
  win_e             win_q;
  logic [LEN_W-1:0] len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_HAMMING;
      len_q <= LEN_W'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WINDOW_TYPE:   win_q <= win_e'(cfg_data_i[1:0]);
        REG_WINDOW_LENGTH: len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: classify the index and build the divide operand
  job_t job;
  job_t head;
  logic fifo_empty;
  logic fifo_full;

  wcg_front u_front (
    .sample_index_i (sample_index_i),
    .win_i          (win_q),
    .len_i          (len_q),
    .job_o          (job)
  );

  assign busy = fifo_full;

  // queue: the back drains one entry every cycle it is not empty
  wcg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !busy),
    .data_i  (job),
    .pop_i   (!fifo_empty),
    .data_o  (head),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  // back: phase or triangle quotient, then cosine and blend
  logic             div_valid;
  logic [QUO_W-1:0] div_quo;
  side_t            div_side;

  wcg_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!fifo_empty),
    .job_i       (head),
    .divisor_i   (len_m1(sat_len(len_q))),
    .out_valid_o (div_valid),
    .quo_o       (div_quo),
    .side_o      (div_side)
  );

  wcg_cos u_cos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .quo_i       (div_quo),
    .side_i      (div_side),
    .out_valid_o (result_valid_o),
    .coef_o      (coefficient_o),
    .oor_o       (index_out_of_range_o)
  );

endmodule

`default_nettype wire

// ----- sv/wcg_checker.sv -----
// ----------------------------------------------------------------------------
// wcg_checker
// port-level checks for the window coefficient generator
// ----------------------------------------------------------------------------
`default_nettype none

module wcg_checker import wcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic              result_valid_o,
  input  logic [COEF_W-1:0] coefficient_o,
  input  logic              index_out_of_range_o
);

  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##RESULT_LATENCY result_valid_o)
    else $error("result missing after command transfer");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, RESULT_LATENCY))
    else $error("result without command transfer");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && index_out_of_range_o |-> coefficient_o == '0)
    else $error("out of range result with nonzero weight");

  a_coef_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> coefficient_o <= COEF_W'(1 << FRAC_BITS))
    else $error("weight above one");

endmodule

bind window_coefficient_generator_unit wcg_checker u_wcg_checker (.*);

`default_nettype wire
